/* rtl/cfil_pkg.sv */
// Shared types, constants and helper functions for the corner fillet pipeline.
// Used by corner_fillet_geometry and cfil_checker; depends on nothing.
package cfil_pkg;

  // Coordinate and internal widths
  localparam int COORD_W    = 32;
  localparam int LEN_W      = 33;   // side length, floor of the Euclidean norm
  localparam int UNIT_W     = 32;   // unit vector component, signed Q2.30
  localparam int CORD_W     = 38;   // CORDIC working width
  localparam int ACC_W      = 34;   // CORDIC angle accumulator
  localparam int CORD_STEPS = 30;
  localparam int QUO_W      = 53;   // distance and centre offset quotients

  // Straight-line threshold on |sin| in Q60
  localparam logic [63:0] SIN_EPS = 64'd1152921504607;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_SIDE = 3'd1;
  localparam logic [2:0] ST_STRAIGHT  = 3'd2;
  localparam logic [2:0] ST_SHORT     = 3'd3;

  // Configuration register indexes
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_TOL    = 1'b1;

  // Carried alongside the square-root stages
  typedef struct packed {
    logic [3:0][31:0] mag;   // |v1x| |v1y| |v2x| |v2y|
    logic [3:0]       neg;
    logic [31:0]      cx;
    logic [31:0]      cy;
  } p1_t;

  // Carried alongside the unit-vector dividers
  typedef struct packed {
    logic [3:0]       neg;
    logic [LEN_W-1:0] mn;
    logic             st1;
    logic [31:0]      cx;
    logic [31:0]      cy;
  } p2_t;

  // Carried alongside the distance and centre dividers; holds the CORDIC
  typedef struct packed {
    logic                     st1;
    logic                     st2;
    logic [LEN_W-1:0]         mn;
    logic [3:0][UNIT_W-1:0]   u;
    logic                     sxneg;
    logic                     syneg;
    logic                     xpos;
    logic [31:0]              cx;
    logic [31:0]              cy;
    logic signed [CORD_W-1:0] cor_x;
    logic signed [CORD_W-1:0] cor_y;
    logic signed [ACC_W-1:0]  acc;
  } p3_t;

  // atan(2^-i) in units of pi/2^31
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051E;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2FA;
      5'd15: v = 30'h0000517D;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A30;
      5'd19: v = 30'h00000518;
      5'd20: v = 30'h0000028C;
      5'd21: v = 30'h00000146;
      5'd22: v = 30'h000000A3;
      5'd23: v = 30'h00000051;
      5'd24: v = 30'h00000029;
      5'd25: v = 30'h00000014;
      5'd26: v = 30'h0000000A;
      5'd27: v = 30'h00000005;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

  // Clamp a wide signed value to the coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [55:0] v);
    logic [COORD_W-1:0] r;
    if (v > 56'sh7FFFFFFF) r = 32'h7FFFFFFF;
    else if (v < -56'sh80000000) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* rtl/cfil_sqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Generic; no package dependencies.
module cfil_sqrt #(
  parameter int RAD_W  = 65,
  parameter int ROOT_W = 33
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  localparam int W = 2 * ROOT_W + 1;

  logic [W-1:0]      rem [ROOT_W];
  logic [ROOT_W-1:0] rt  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [W-1:0]      rem_in;
    logic [W-1:0]      trial;
    logic [ROOT_W-1:0] rt_in;

    if (k == 0) begin : g_first
      assign rem_in = W'(rad);
      assign rt_in  = '0;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign rt_in  = rt[k-1];
    end

    // (root + 2^B)^2 - root^2 = root*2^(B+1) + 2^(2B)
    assign trial = (W'(rt_in) << (B + 1)) | (W'(1) << (2 * B));

    // Decide one root bit
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem[k] <= rem_in - trial;
          rt[k]  <= rt_in | (ROOT_W'(1) << B);
        end else begin
          rem[k] <= rem_in;
          rt[k]  <= rt_in;
        end
      end
    end
  end

  assign root = rt[ROOT_W-1];

endmodule

/* rtl/cfil_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Generic; needs num < den * 2^QUO_W. No package dependencies.
module cfil_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 33,
  parameter int QUO_W = 31
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  localparam int W = DEN_W + QUO_W;

  logic [W-1:0]     rem [QUO_W];
  logic [DEN_W-1:0] dv  [QUO_W];
  logic [QUO_W-1:0] qv  [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int SH = QUO_W - 1 - k;
    logic [W-1:0]     rem_in;
    logic [W-1:0]     trial;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] q_in;

    if (k == 0) begin : g_first
      assign rem_in = W'(num);
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign den_in = dv[k-1];
      assign q_in   = qv[k-1];
    end

    assign trial = W'(den_in) << SH;

    // Subtract the shifted divisor where it fits
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k] <= den_in;
        if (rem_in >= trial) begin
          rem[k] <= rem_in - trial;
          qv[k]  <= q_in | (QUO_W'(1) << SH);
        end else begin
          rem[k] <= rem_in;
          qv[k]  <= q_in;
        end
      end
    end
  end

  assign quo = qv[QUO_W-1];

endmodule

/* rtl/corner_fillet_geometry.sv */
// Corner fillet geometry: top level, one corner per transfer through a deep pipeline.
// Depends on cfil_pkg, cfil_sqrt and cfil_div.
//
// Usage:
//   s_axis carries one corner per transfer: previous, corner and next point as
//   signed Q16.16. m_axis returns one result per corner: the status in tuser and
//   the tangent points, arc centre, sweep and direction flag in tdata (all zero
//   unless the status is ok).
//   The cfg port writes the fillet radius (index 0) and the length tolerance
//   (index 1); write only while no corner is in flight.
//   A corner passes from the accepting edge to tvalid through 125 register
//   stages: 3 setup stages, 33 square-root stages, 31 unit-vector divider stages,
//   3 product stages, 53 distance/centre divider stages (the CORDIC runs inside
//   these) and 2 output stages. The long division over 53 quotient bits sets the
//   depth.
//   Throughput is one corner per cycle while m_axis_tready is high.
//   Reset clears every valid bit and loads radius 5.0 and tolerance 1 LSB.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_axis_tready drops; nothing is lost or repeated.
module corner_fillet_geometry (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,   // prev_x, prev_y, corner_x, corner_y, next_x, next_y
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [215:0] m_axis_tdata,   // t1_x, t1_y, t2_x, t2_y, center_x, center_y,
                                       // sweep_angle, reversed, zero fill
  output logic [2:0]   m_axis_tuser,   // fillet_status
  input  logic         cfg_wr_en,
  input  logic         cfg_addr,
  input  logic [30:0]  cfg_wdata
);

  localparam int SQ_N = cfil_pkg::LEN_W;
  localparam int UD_N = 31;
  localparam int DD_N = cfil_pkg::QUO_W;

  logic        en;
  logic [30:0] fillet_radius;
  logic [15:0] length_tolerance;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fillet_radius    <= 31'd327680;
      length_tolerance <= 16'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        cfil_pkg::REG_RADIUS: fillet_radius    <= cfg_wdata;
        cfil_pkg::REG_TOL:    length_tolerance <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- valid chain
  logic            s1_valid, s2_valid, s3_valid;
  logic [SQ_N-1:0] p1_valid;
  logic [UD_N-1:0] p2_valid;
  logic            mu_valid, ad_valid, pp_valid;
  logic [DD_N-1:0] p3_valid;
  logic            t1_valid;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      p1_valid      <= '0;
      p2_valid      <= '0;
      mu_valid      <= 1'b0;
      ad_valid      <= 1'b0;
      pp_valid      <= 1'b0;
      p3_valid      <= '0;
      t1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      s1_valid      <= s_axis_tvalid;
      s2_valid      <= s1_valid;
      s3_valid      <= s2_valid;
      p1_valid      <= {p1_valid[SQ_N-2:0], s3_valid};
      p2_valid      <= {p2_valid[UD_N-2:0], p1_valid[SQ_N-1]};
      mu_valid      <= p2_valid[UD_N-1];
      ad_valid      <= mu_valid;
      pp_valid      <= ad_valid;
      p3_valid      <= {p3_valid[DD_N-2:0], pp_valid};
      t1_valid      <= p3_valid[DD_N-1];
      m_axis_tvalid <= t1_valid;
    end
  end

  // ---------------------------------------------------------------- stage 1: side vectors
  logic signed [32:0] s1_v [4];
  logic [31:0]        s1_cx, s1_cy;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v[0] <= $signed({s_axis_tdata[31],  s_axis_tdata[31:0]})
               - $signed({s_axis_tdata[95],  s_axis_tdata[95:64]});
      s1_v[1] <= $signed({s_axis_tdata[63],  s_axis_tdata[63:32]})
               - $signed({s_axis_tdata[127], s_axis_tdata[127:96]});
      s1_v[2] <= $signed({s_axis_tdata[159], s_axis_tdata[159:128]})
               - $signed({s_axis_tdata[95],  s_axis_tdata[95:64]});
      s1_v[3] <= $signed({s_axis_tdata[191], s_axis_tdata[191:160]})
               - $signed({s_axis_tdata[127], s_axis_tdata[127:96]});
      s1_cx   <= s_axis_tdata[95:64];
      s1_cy   <= s_axis_tdata[127:96];
    end
  end

  // ---------------------------------------------------------------- stage 2: squares
  logic [3:0][31:0] s2_mag;
  logic [3:0]       s2_neg;
  logic [63:0]      s2_sq [4];
  logic [31:0]      s2_cx, s2_cy;

  always_ff @(posedge clk) begin
    logic [32:0] a;
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        a         = s1_v[i][32] ? 33'(-s1_v[i]) : 33'(s1_v[i]);
        s2_mag[i] <= a[31:0];
        s2_neg[i] <= s1_v[i][32];
        s2_sq[i]  <= a[31:0] * a[31:0];
      end
      s2_cx <= s1_cx;
      s2_cy <= s1_cy;
    end
  end

  // ---------------------------------------------------------------- stage 3: norms squared
  logic [64:0]    s3_n1, s3_n2;
  cfil_pkg::p1_t  s3_rec;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_n1      <= {1'b0, s2_sq[0]} + {1'b0, s2_sq[1]};
      s3_n2      <= {1'b0, s2_sq[2]} + {1'b0, s2_sq[3]};
      s3_rec.mag <= s2_mag;
      s3_rec.neg <= s2_neg;
      s3_rec.cx  <= s2_cx;
      s3_rec.cy  <= s2_cy;
    end
  end

  // ---------------------------------------------------------------- square roots
  logic [cfil_pkg::LEN_W-1:0] l1, l2;
  cfil_pkg::p1_t              p1 [SQ_N];

  cfil_sqrt #(.RAD_W(65), .ROOT_W(SQ_N)) u_sqrt1 (
    .clk(clk), .en(en), .rad(s3_n1), .root(l1)
  );
  cfil_sqrt #(.RAD_W(65), .ROOT_W(SQ_N)) u_sqrt2 (
    .clk(clk), .en(en), .rad(s3_n2), .root(l2)
  );

  // Carry the side data past the root stages
  always_ff @(posedge clk) begin
    if (en) begin
      p1[0] <= s3_rec;
      for (int i = 1; i < SQ_N; i++) p1[i] <= p1[i-1];
    end
  end

  // ---------------------------------------------------------------- unit vectors
  logic [62:0]                ud_num [4];
  logic [cfil_pkg::LEN_W-1:0] ud_den [4];
  logic [UD_N-1:0]            ud_quo [4];
  cfil_pkg::p2_t              p2_in;
  cfil_pkg::p2_t              p2 [UD_N];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ud_den[i] = (i < 2) ? l1 : l2;
      ud_num[i] = {1'b0, p1[SQ_N-1].mag[i], 30'b0} + 63'(ud_den[i] >> 1);
    end
    p2_in.neg = p1[SQ_N-1].neg;
    p2_in.mn  = (l1 < l2) ? l1 : l2;
    p2_in.st1 = (l1 == '0) || (l2 == '0)
             || (l1 < {17'b0, length_tolerance}) || (l2 < {17'b0, length_tolerance});
    p2_in.cx  = p1[SQ_N-1].cx;
    p2_in.cy  = p1[SQ_N-1].cy;
  end

  for (genvar g = 0; g < 4; g++) begin : g_unit
    cfil_div #(.NUM_W(63), .DEN_W(cfil_pkg::LEN_W), .QUO_W(UD_N)) u_div (
      .clk(clk), .en(en), .num(ud_num[g]), .den(ud_den[g]), .quo(ud_quo[g])
    );
  end

  // Carry the side data past the unit dividers
  always_ff @(posedge clk) begin
    if (en) begin
      p2[0] <= p2_in;
      for (int i = 1; i < UD_N; i++) p2[i] <= p2[i-1];
    end
  end

  // ---------------------------------------------------------------- cosine and sine products
  logic [3:0][cfil_pkg::UNIT_W-1:0] mu_u;
  logic signed [63:0]               mu_pxx, mu_pyy, mu_pxy, mu_pyx;
  logic [cfil_pkg::LEN_W-1:0]       mu_mn;
  logic                             mu_st1;
  logic [31:0]                      mu_cx, mu_cy;
  logic signed [31:0]               uc [4];

  // Clamp the quotient to 1.0 and restore the sign
  always_comb begin
    logic [30:0] m;
    for (int i = 0; i < 4; i++) begin
      m     = (ud_quo[i] > 31'h40000000) ? 31'h40000000 : ud_quo[i];
      uc[i] = p2[UD_N-1].neg[i] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) mu_u[i] <= uc[i];
      mu_pxx <= uc[0] * uc[2];
      mu_pyy <= uc[1] * uc[3];
      mu_pxy <= uc[0] * uc[3];
      mu_pyx <= uc[1] * uc[2];
      mu_mn  <= p2[UD_N-1].mn;
      mu_st1 <= p2[UD_N-1].st1;
      mu_cx  <= p2[UD_N-1].cx;
      mu_cy  <= p2[UD_N-1].cy;
    end
  end

  // ---------------------------------------------------------------- dot, cross, bisector
  logic signed [63:0]               ad_d, ad_x;
  logic signed [32:0]               ad_sx, ad_sy;
  logic [3:0][cfil_pkg::UNIT_W-1:0] ad_u;
  logic [cfil_pkg::LEN_W-1:0]       ad_mn;
  logic                             ad_st1;
  logic [31:0]                      ad_cx, ad_cy;

  always_ff @(posedge clk) begin
    if (en) begin
      ad_d   <= mu_pxx + mu_pyy;
      ad_x   <= mu_pxy - mu_pyx;
      ad_sx  <= $signed({mu_u[0][31], mu_u[0]}) + $signed({mu_u[2][31], mu_u[2]});
      ad_sy  <= $signed({mu_u[1][31], mu_u[1]}) + $signed({mu_u[3][31], mu_u[3]});
      ad_u   <= mu_u;
      ad_mn  <= mu_mn;
      ad_st1 <= mu_st1;
      ad_cx  <= mu_cx;
      ad_cy  <= mu_cy;
    end
  end

  // ---------------------------------------------------------------- divider operands, CORDIC entry
  logic [64:0]   pp_pd;
  logic [33:0]   pp_bq;
  logic [32:0]   pp_xq;
  logic [62:0]   pp_pcx, pp_pcy;
  cfil_pkg::p3_t pp_rec;

  always_ff @(posedge clk) begin
    logic [63:0]        ax;
    logic signed [63:0] asum;
    logic [63:0]        acl;
    logic [32:0]        asx, asy;
    logic signed [63:0] nd;
    logic signed [cfil_pkg::CORD_W-1:0] x0, y0;
    if (en) begin
      ax   = ad_x[63] ? 64'(-ad_x) : 64'(ad_x);
      asum = 64'sh1000000000000000 + ad_d;
      if (asum < 0) acl = '0;
      else if (asum > 64'sh2000000000000000) acl = 64'h2000000000000000;
      else acl = 64'(asum);
      asx  = ad_sx[32] ? 33'(-ad_sx) : 33'(ad_sx);
      asy  = ad_sy[32] ? 33'(-ad_sy) : 33'(ad_sy);
      nd   = (-ad_d) >>> 28;
      x0   = nd[cfil_pkg::CORD_W-1:0];
      y0   = $signed({4'b0, ax[61:28]});

      pp_pd  <= fillet_radius * acl[61:28];
      pp_bq  <= ax[61:28];
      pp_xq  <= ax[61:29];
      pp_pcx <= fillet_radius * asx[31:0];
      pp_pcy <= fillet_radius * asy[31:0];

      pp_rec.st1   <= ad_st1;
      pp_rec.st2   <= ax < cfil_pkg::SIN_EPS;
      pp_rec.mn    <= ad_mn;
      pp_rec.u     <= ad_u;
      pp_rec.sxneg <= ad_sx[32];
      pp_rec.syneg <= ad_sy[32];
      pp_rec.xpos  <= ad_x > 0;
      pp_rec.cx    <= ad_cx;
      pp_rec.cy    <= ad_cy;
      // Pre-rotate by a quarter turn when the vector points left
      if (x0 < 0) begin
        pp_rec.cor_x <= y0;
        pp_rec.cor_y <= -x0;
        pp_rec.acc   <= cfil_pkg::ACC_W'(34'sh40000000);
      end else begin
        pp_rec.cor_x <= x0;
        pp_rec.cor_y <= y0;
        pp_rec.acc   <= '0;
      end
    end
  end

  // ---------------------------------------------------------------- distance and centre dividers
  logic [64:0]     dd_num;
  logic [63:0]     cx_num, cy_num;
  logic [DD_N-1:0] dist_q, offx_q, offy_q;

  assign dd_num = pp_pd + 65'(pp_bq >> 1);
  assign cx_num = {pp_pcx, 1'b0} + 64'(pp_xq >> 1);
  assign cy_num = {pp_pcy, 1'b0} + 64'(pp_xq >> 1);

  cfil_div #(.NUM_W(65), .DEN_W(34), .QUO_W(DD_N)) u_div_dist (
    .clk(clk), .en(en), .num(dd_num), .den(pp_bq), .quo(dist_q)
  );
  cfil_div #(.NUM_W(64), .DEN_W(33), .QUO_W(DD_N)) u_div_offx (
    .clk(clk), .en(en), .num(cx_num), .den(pp_xq), .quo(offx_q)
  );
  cfil_div #(.NUM_W(64), .DEN_W(33), .QUO_W(DD_N)) u_div_offy (
    .clk(clk), .en(en), .num(cy_num), .den(pp_xq), .quo(offy_q)
  );

  // One CORDIC vectoring step per stage for the first CORD_STEPS stages, alongside the dividers
  function automatic cfil_pkg::p3_t cordic_step(input cfil_pkg::p3_t r, input int i);
    cfil_pkg::p3_t o;
    logic signed [cfil_pkg::CORD_W-1:0] dx, dy;
    logic signed [cfil_pkg::ACC_W-1:0]  at;
    o  = r;
    dx = r.cor_x >>> i;
    dy = r.cor_y >>> i;
    at = $signed({4'b0, cfil_pkg::atan_entry(5'(i))});
    if (r.cor_y >= 0) begin
      o.cor_x = r.cor_x + dy;
      o.cor_y = r.cor_y - dx;
      o.acc   = r.acc + at;
    end else begin
      o.cor_x = r.cor_x - dy;
      o.cor_y = r.cor_y + dx;
      o.acc   = r.acc - at;
    end
    return o;
  endfunction

  cfil_pkg::p3_t p3 [DD_N];

  always_ff @(posedge clk) begin
    if (en) begin
      p3[0] <= pp_rec;
      for (int k = 1; k < DD_N; k++) begin
        if (k <= cfil_pkg::CORD_STEPS) p3[k] <= cordic_step(p3[k-1], k - 1);
        else p3[k] <= p3[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- status, centre, sweep, partials
  localparam int ACC_SUM_W = cfil_pkg::ACC_W + 1;

  cfil_pkg::p3_t t1_in;
  logic [2:0]    t1_status;
  logic [31:0]   t1_cenx, t1_ceny;
  logic [15:0]   t1_sweep;
  logic          t1_rev;
  logic [47:0]   t1_pl [4];
  logic [47:0]   t1_ph [4];
  logic [3:0]    t1_neg;
  logic [31:0]   t1_cx, t1_cy;

  assign t1_in = p3[DD_N-1];

  always_ff @(posedge clk) begin
    logic signed [33:0] lim;
    logic               st3;
    logic [30:0]        au;
    logic signed [55:0] off;
    logic signed [ACC_SUM_W-1:0] rnd;
    logic [14:0]        mag;
    if (en) begin
      lim = $signed({1'b0, t1_in.mn}) - $signed({18'b0, length_tolerance});
      st3 = $signed({2'b0, dist_q}) > $signed({{21{lim[33]}}, lim});
      if (t1_in.st1)      t1_status <= cfil_pkg::ST_ZERO_SIDE;
      else if (t1_in.st2) t1_status <= cfil_pkg::ST_STRAIGHT;
      else if (st3)       t1_status <= cfil_pkg::ST_SHORT;
      else                t1_status <= cfil_pkg::ST_OK;

      // Tangent offsets: |u| * dist split into two 17-bit halves
      for (int i = 0; i < 4; i++) begin
        au        = t1_in.u[i][31] ? 31'(-$signed(t1_in.u[i])) : t1_in.u[i][30:0];
        t1_pl[i]  <= au * dist_q[16:0];
        t1_ph[i]  <= au * dist_q[33:17];
        t1_neg[i] <= t1_in.u[i][31];
      end

      // Arc centre
      off     = t1_in.sxneg ? -$signed({3'b0, offx_q}) : $signed({3'b0, offx_q});
      t1_cenx <= cfil_pkg::sat_coord($signed({{24{t1_in.cx[31]}}, t1_in.cx}) + off);
      off     = t1_in.syneg ? -$signed({3'b0, offy_q}) : $signed({3'b0, offy_q});
      t1_ceny <= cfil_pkg::sat_coord($signed({{24{t1_in.cy[31]}}, t1_in.cy}) + off);

      // Round the angle to 16 bits and apply the turn direction
      rnd = t1_in.acc + ACC_SUM_W'(35'sd32768);
      if (t1_in.acc < 0) mag = '0;
      else if (rnd[ACC_SUM_W-1:16] > 19'sd32767) mag = 15'h7FFF;
      else mag = rnd[30:16];
      t1_sweep <= t1_in.xpos ? -{1'b0, mag} : {1'b0, mag};
      t1_rev   <= t1_in.xpos;

      t1_cx <= t1_in.cx;
      t1_cy <= t1_in.cy;
    end
  end

  // ---------------------------------------------------------------- output register
  logic [31:0] tan_c [4];

  always_comb begin
    logic [64:0]        sum;
    logic signed [55:0] d;
    logic [31:0]        base;
    for (int i = 0; i < 4; i++) begin
      sum  = {t1_ph[i], 17'b0} + {17'b0, t1_pl[i]} + 65'h20000000;
      d    = t1_neg[i] ? -$signed({21'b0, sum[64:30]}) : $signed({21'b0, sum[64:30]});
      base = (i % 2 == 0) ? t1_cx : t1_cy;
      tan_c[i] = cfil_pkg::sat_coord($signed({{24{base[31]}}, base}) + d);
    end
  end

  // Zero every result field on a failed corner
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tuser <= t1_status;
      if (t1_status == cfil_pkg::ST_OK) begin
        m_axis_tdata <= {7'b0, t1_rev, t1_sweep, t1_ceny, t1_cenx,
                         tan_c[3], tan_c[2], tan_c[1], tan_c[0]};
      end else begin
        m_axis_tdata <= '0;
      end
    end
  end

endmodule

/* rtl/cfil_checker.sv */
// Port-level checks for corner_fillet_geometry, attached by bind.
// Depends on cfil_pkg for the status codes.
module cfil_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [215:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Failed corners carry no geometry
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != cfil_pkg::ST_OK |-> m_axis_tdata == '0)
    else $error("failed corner with nonzero data");

  // Only the four defined codes appear
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser == cfil_pkg::ST_OK || m_axis_tuser == cfil_pkg::ST_ZERO_SIDE
      || m_axis_tuser == cfil_pkg::ST_STRAIGHT || m_axis_tuser == cfil_pkg::ST_SHORT)
    else $error("undefined status code");

  // Sweep sign agrees with the direction flag
  a_sweep_sign: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == cfil_pkg::ST_OK
      |-> (m_axis_tdata[208] ? (m_axis_tdata[207] || m_axis_tdata[207:192] == 16'h0)
                             : !m_axis_tdata[207]))
    else $error("sweep sign disagrees with reversed flag");

endmodule

bind corner_fillet_geometry cfil_checker u_cfil_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
